FILE: rtl/stsd_pkg.sv
// Shared types, codes and constants of the sorted table.
package stsd_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned FIELD_W      = 7;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAPACITY_DEF = 64;
  // status, found, first_position, match_count, entry_count; already whole bytes
  localparam int unsigned OUT_TDATA_W  = STATUS_W + 1 + 3 * FIELD_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              eval;   // capture compare flags
    logic              ins;    // insert: shift up from the insertion point
    logic              del;    // delete: shift down from the first match
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // Result fields in tdata order, lowest bits last in the struct.
  typedef struct packed {
    logic [FIELD_W-1:0] entry_count;
    logic [FIELD_W-1:0] match_count;
    logic [FIELD_W-1:0] first_position;
    logic               found;
    status_e            status;
  } result_t;

endpackage

FILE: rtl/stsd_cell.sv
// One slot of the sorted table: entry, compare flags and neighbour shifting.
module stsd_cell
  import stsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic              valid_i,       // slot lies below the fill count
  input  logic [DATA_W-1:0] left_entry_i,
  input  logic [DATA_W-1:0] right_entry_i,
  input  logic              left_lt_i,     // tied high on the first cell
  input  logic              left_eq_i,     // tied low on the first cell
  input  logic              right_eq_i,    // tied low on the last cell
  output logic [DATA_W-1:0] entry_o,
  output logic              lt_o,
  output logic              eq_o,
  output logic              first_o,       // first entry of the equal run
  output logic              last_o         // last entry of the equal run
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              lt_q, lt_d;
  logic              eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmd_i.eval) begin
      lt_d = valid_i && ($signed(entry_q) < $signed(cmd_i.value));
      eq_d = valid_i && (entry_q == cmd_i.value);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && !lt_q) begin
      // insertion point takes the new value, slots above move up by one
      entry_d = left_lt_i ? cmd_i.value : left_entry_i;
    end else if (cmd_i.del && !lt_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign first_o = eq_q && !left_eq_i;
  assign last_o  = eq_q && !right_eq_i;

endmodule

FILE: rtl/sorted_table_insert_search_delete.sv
// Top level of the sorted table: request control, cell row and result register.
//
// Holds up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, one value per cell. Each request (opcode in tuser, value in tdata)
// gives exactly one result transfer. A request passes the states EVAL and APPLY:
// in EVAL every cell compares its own entry with the value and registers
// "smaller" and "equal" flags; in APPLY the result is written to the output
// register and, for insert or delete, the row shifts by one slot towards or
// away from the insertion point or first match. The next request is taken in
// APPLY, while the current one finishes; a result still waiting in the output
// register holds the request in APPLY. A new value is inserted ahead of any
// equal values already held. Insert into a full table gives status full and
// leaves it unchanged; search and delete of an absent value give status not
// found. Clear only resets the fill count. Counts wider than seven bits wrap
// in the result fields. No clearing pass is needed after reset.
module sorted_table_insert_search_delete
  import stsd_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] value
  input  logic [OP_W-1:0]        s_axis_tuser,   // [1:0] opcode
  // result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [2] found, [9:3] first_position, [16:10] match_count,
  // [23:17] entry_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------- control
  state_e            state_q, state_d;
  op_e               op_q;
  logic [DATA_W-1:0] value_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;

  logic      s_fire;
  logic      can_finish;   // output register free or draining this cycle
  logic      finish;
  logic      hit;
  logic      full;
  cell_cmd_t cmd;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign can_finish = !out_valid_q || m_axis_tready;
  assign full       = (count_q == CntW'(CAPACITY));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: begin
        if (can_finish) state_d = s_fire ? S_EVAL : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    finish        = 1'b0;
    cmd.eval      = 1'b0;
    cmd.ins       = 1'b0;
    cmd.del       = 1'b0;
    cmd.value     = value_q;
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_EVAL:  cmd.eval = 1'b1;
      S_APPLY: begin
        s_axis_tready = can_finish;
        finish        = can_finish;
        cmd.ins       = can_finish && (op_q == OP_INSERT) && !full;
        cmd.del       = can_finish && (op_q == OP_DELETE) && hit;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------- cell row
  logic [DATA_W-1:0] entry   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid, lt, eq, first_hit, last_hit;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_entry, right_entry;
    logic              left_lt, left_eq, right_eq;

    if (g == 0) begin : g_head
      assign left_entry = entry[g];
      assign left_lt    = 1'b1;
      assign left_eq    = 1'b0;
    end else begin : g_mid_l
      assign left_entry = entry[g-1];
      assign left_lt    = lt[g-1];
      assign left_eq    = eq[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[g];
      assign right_eq    = 1'b0;
    end else begin : g_mid_r
      assign right_entry = entry[g+1];
      assign right_eq    = eq[g+1];
    end

    assign cell_valid[g] = (CntW'(g) < count_q);

    stsd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .valid_i      (cell_valid[g]),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .left_lt_i    (left_lt),
      .left_eq_i    (left_eq),
      .right_eq_i   (right_eq),
      .entry_o      (entry[g]),
      .lt_o         (lt[g]),
      .eq_o         (eq[g]),
      .first_o      (first_hit[g]),
      .last_o       (last_hit[g])
    );
  end

  // equal run is contiguous, so its ends are one-hot: encode them by OR
  logic [IdxW-1:0] first_idx, last_idx;

  always_comb begin
    first_idx = '0;
    last_idx  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) first_idx = first_idx | IdxW'(i);
      if (last_hit[i])  last_idx  = last_idx  | IdxW'(i);
    end
  end

  assign hit = |eq;

  // ---------------------------------------------------------------- result
  logic [CntW-1:0] first_pos, run_len;

  assign first_pos = CntW'(first_idx) + CntW'(1);
  assign run_len   = CntW'(last_idx) - CntW'(first_idx) + CntW'(1);

  always_comb begin
    count_d                 = count_q;
    result_d                = result_q;
    if (finish) begin
      result_d.status         = ST_DONE;
      result_d.found          = 1'b0;
      result_d.first_position = '0;
      result_d.match_count    = '0;
      case (op_q)
        OP_INSERT: begin
          if (full) result_d.status = ST_FULL;
          else      count_d = count_q + CntW'(1);
        end
        OP_SEARCH: begin
          if (hit) begin
            result_d.found          = 1'b1;
            result_d.first_position = FIELD_W'(first_pos);
            result_d.match_count    = FIELD_W'(run_len);
          end else begin
            result_d.status = ST_NOT_FOUND;
          end
        end
        OP_DELETE: begin
          if (hit) count_d = count_q - CntW'(1);
          else     result_d.status = ST_NOT_FOUND;
        end
        OP_CLEAR: count_d = '0;
        default:  ;
      endcase
      result_d.entry_count = FIELD_W'(count_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish)             out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q    <= op_e'(s_axis_tuser);
      value_q <= s_axis_tdata;
    end
    result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

endmodule
